>>> rtl/vks_pkg.sv
// ---------------------------------------------------------------------------
// vks_pkg: shared types and constants for the vehicle kinematic step
// Fixed-point constants, shared-unit request/response types, sequencer
// states and the quarter-wave sine contents.
// ---------------------------------------------------------------------------
package vks_pkg;

	// quarter-wave table; index math assumes a power of two
	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);
	localparam int SINE_W             = 16;

	localparam int IN_W  = 48;
	localparam int OUT_W = 128;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// compare/subtract width, wide enough for the biased heading sum
	localparam int CS_W = 34;
	localparam logic [CS_W-1:0] QUARTER_DEG = 34'd5898240;
	localparam logic [CS_W-1:0] FULL_DEG    = 34'd23592960;
	localparam int MOD_STEPS = 8;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int CNT_W = $clog2((SINE_IDX_W > MOD_STEPS) ? SINE_IDX_W : MOD_STEPS);

	localparam logic signed [15:0] DEADBAND = 16'sd25;

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FWD_SPEED,
		REG_BWD_SPEED,
		REG_LEFT_STEER,
		REG_RIGHT_STEER
	} cfg_reg_t;

	typedef enum logic {
		ALU_MUL,
		ALU_CSUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t               op;
		logic [MUL_A_W-1:0]    mul_a;
		logic [MUL_B_W-1:0]    mul_b;
		logic [CS_W-1:0]       cs_a;
		logic [CS_W-1:0]       cs_b;
	} alu_req_t;

	typedef struct packed {
		logic [MUL_P_W-1:0]    prod;
		logic [CS_W-1:0]       rem;
		logic                  ge;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_QUAD_HI,
		ST_QUAD_LO,
		ST_DIV,
		ST_LAG_SP,
		ST_LAG_ST,
		ST_VEL,
		ST_MUL_X,
		ST_MUL_Z,
		ST_MUL_H,
		ST_MOD_INIT,
		ST_MOD,
		ST_DONE
	} state_t;

	typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_ENTRIES];

	// shift-and-subtract quotient, used only while building the table
	function automatic longint unsigned udiv64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// floor(65536*sin(90deg*i/N)) by a 13-term Taylor series in Q30,
	// evaluated at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t      rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
			x    = (PI_HALF_Q30 * longint'(i)) >> SINE_IDX_W;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 12; k++) begin
				term = udiv64((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
				if ((k & 1) == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			sum = sum >>> 14;
			if (sum > 65535)
				sum = 65535;
			rom[i] = SINE_W'(sum);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/vks_ram.sv
// ---------------------------------------------------------------------------
// vks_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ---------------------------------------------------------------------------
module vks_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/vks_alu.sv
// ---------------------------------------------------------------------------
// vks_alu: shared arithmetic unit
// Signed 33x18 multiply, or unsigned compare and conditional subtract.
// ---------------------------------------------------------------------------
module vks_alu (
	input  vks_pkg::alu_req_t req,
	output vks_pkg::alu_rsp_t rsp
);
	import vks_pkg::*;

	logic signed [MUL_P_W-1:0] prod;
	logic                      ge;

	assign prod = $signed(req.mul_a) * $signed(req.mul_b);
	assign ge   = (req.cs_a >= req.cs_b);

	always_comb begin
		rsp.prod = '0;
		rsp.rem  = '0;
		rsp.ge   = 1'b0;
		case (req.op)
			ALU_MUL: begin
				rsp.prod = prod;
			end
			ALU_CSUB: begin
				rsp.ge  = ge;
				rsp.rem = ge ? (req.cs_a - req.cs_b) : req.cs_a;
			end
			default: begin
				rsp.prod = '0;
			end
		endcase
	end

endmodule

>>> rtl/vehicle_kinematic_step.sv
// ---------------------------------------------------------------------------
// vehicle_kinematic_step: unicycle pose update, one Euler step per item
// A sequencer drives one shared multiply / compare-subtract unit through
// the lag, trig lookup, position and heading steps of each item.
// ---------------------------------------------------------------------------
// Steps: from input accept to m_tvalid an item passes the quadrant, index
//   divide, multiply, heading wrap and output load steps.
// Items: a new item is accepted only in idle, once the last is done, as
//   set by the shared unit; a pose held by m_tready stalls the next item.
// Reset: arst_n clears the pose and restores the default limits, then the
//   sine RAM is loaded in a full pass with s_tready low.
module vehicle_kinematic_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// target_speed[15:0], target_steering[31:16], time_step[47:32]
	input  logic [vks_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pos_x[31:0], pos_z[63:32], heading[88:64], speed_now[104:89],
	// steering_now[120:105], zero fill above
	output logic [vks_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_we,
	input  logic [vks_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [vks_pkg::CFG_W-1:0]     cfg_data
);
	import vks_pkg::*;

	state_t state_q, state_d;

	// limits
	logic signed [15:0] fwd_lim_q, bwd_lim_q, left_lim_q, right_lim_q;

	// pose state
	logic signed [15:0] cur_sp_q, cur_st_q;
	logic [31:0]        x_q, z_q;
	logic [24:0]        hd_q;

	// per-item working registers
	logic signed [15:0]        tsp_q, tst_q;
	logic [15:0]               dt_q;
	logic [24:0]               rw_q;
	logic [1:0]                quad_q;
	logic [SINE_IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]          step_q;
	logic [SINE_W-1:0]         ma_q;
	logic signed [15:0]        sp_q, st_q;
	logic signed [17:0]        c_q, s_q;
	logic signed [MUL_A_W-1:0] p_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic [31:0]               x_new_q, z_new_q;
	logic [CS_W-1:0]           v_q;
	logic [SINE_IDX_W-1:0]     fill_q;

	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	alu_req_t req;
	alu_rsp_t rsp;

	logic                  ram_we;
	logic [SINE_IDX_W-1:0] ram_addr;
	logic [SINE_W-1:0]     ram_rdata;

	logic in_acc, out_free;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	vks_alu u_alu (
		.req (req),
		.rsp (rsp)
	);

	vks_ram #(
		.WIDTH (SINE_W),
		.DEPTH (SINE_TABLE_ENTRIES)
	) u_sine_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (SINE_ROM[fill_q]),
		.rdata (ram_rdata)
	);

	function automatic logic signed [15:0] clamp16(
		input logic signed [25:0] v,
		input logic signed [15:0] a,
		input logic signed [15:0] b
	);
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [15:0] r;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (v < lo)
			r = lo;
		else if (v > hi)
			r = hi;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] deadband16(input logic signed [15:0] v);
		if (v <= DEADBAND && v >= -DEADBAND)
			return 16'sd0;
		return v;
	endfunction

	// operand and post-processing datapath
	logic signed [16:0]        diff_sp, diff_st;
	logic signed [MUL_P_W-1:0] sp_shift, st_six, st_shift, x_shift, dh_shift;
	logic signed [25:0]        sp_sum, st_sum;
	logic [16:0]               mag_a, mag_b, s_mag, c_mag;
	logic signed [17:0]        s_ext, c_ext, s_val, c_val;
	logic [SINE_IDX_W:0]       nidx_full;

	assign diff_sp  = $signed({tsp_q[15], tsp_q}) - $signed({cur_sp_q[15], cur_sp_q});
	assign diff_st  = $signed({tst_q[15], tst_q}) - $signed({cur_st_q[15], cur_st_q});
	// gain 4: *4 / 2^16
	assign sp_shift = prod_q >>> 14;
	assign sp_sum   = $signed({{10{cur_sp_q[15]}}, cur_sp_q}) + $signed(sp_shift[25:0]);
	// gain 6: (*4 + *2) / 2^16
	assign st_six   = (prod_q <<< 2) + (prod_q <<< 1);
	assign st_shift = st_six >>> 16;
	assign st_sum   = $signed({{10{cur_st_q[15]}}, cur_st_q}) + $signed(st_shift[25:0]);
	assign x_shift  = prod_q >>> 24;
	assign dh_shift = prod_q >>> 16;

	// quarter-wave: odd quadrants mirror the index; index 0 mirrored is 1.0
	assign nidx_full = (SINE_IDX_W + 1)'(SINE_TABLE_ENTRIES) - {1'b0, idx_q};
	assign mag_a = {1'b0, ma_q};
	assign mag_b = (idx_q == '0) ? 17'h10000 : {1'b0, ram_rdata};
	assign s_mag = quad_q[0] ? mag_b : mag_a;
	assign c_mag = quad_q[0] ? mag_a : mag_b;
	assign s_ext = $signed({1'b0, s_mag});
	assign c_ext = $signed({1'b0, c_mag});
	assign s_val = quad_q[1] ? -s_ext : s_ext;
	// cosine sits one quadrant ahead: negative in quadrants 1 and 2
	assign c_val = (quad_q[1] ^ quad_q[0]) ? -c_ext : c_ext;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL:     if (fill_q == SINE_IDX_W'(SINE_TABLE_ENTRIES - 1)) state_d = ST_IDLE;
			ST_IDLE:     if (in_acc) state_d = ST_QUAD_HI;
			ST_QUAD_HI:  state_d = ST_QUAD_LO;
			ST_QUAD_LO:  state_d = ST_DIV;
			ST_DIV:      if (step_q == '0) state_d = ST_LAG_SP;
			ST_LAG_SP:   state_d = ST_LAG_ST;
			ST_LAG_ST:   state_d = ST_VEL;
			ST_VEL:      state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_Z;
			ST_MUL_Z:    state_d = ST_MUL_H;
			ST_MUL_H:    state_d = ST_MOD_INIT;
			ST_MOD_INIT: state_d = ST_MOD;
			ST_MOD:      if (step_q == '0) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.op    = ALU_MUL;
		req.mul_a = '0;
		req.mul_b = '0;
		req.cs_a  = '0;
		req.cs_b  = '0;
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		s_tready  = 1'b0;
		case (state_q)
			ST_FILL: begin
				ram_we   = 1'b1;
				ram_addr = fill_q;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_QUAD_HI: begin
				req.op   = ALU_CSUB;
				req.cs_a = {{(CS_W - 25){1'b0}}, hd_q};
				req.cs_b = QUARTER_DEG << 1;
			end
			ST_QUAD_LO: begin
				req.op   = ALU_CSUB;
				req.cs_a = {{(CS_W - 25){1'b0}}, rw_q};
				req.cs_b = QUARTER_DEG;
			end
			ST_DIV: begin
				// restoring divide of remainder*N by a quarter turn
				req.op   = ALU_CSUB;
				req.cs_a = {{(CS_W - 24){1'b0}}, rw_q[22:0], 1'b0};
				req.cs_b = QUARTER_DEG;
			end
			ST_LAG_SP: begin
				req.mul_a = MUL_A_W'(diff_sp);
				req.mul_b = {2'b00, dt_q};
				ram_addr  = idx_q;
			end
			ST_LAG_ST: begin
				req.mul_a = MUL_A_W'(diff_st);
				req.mul_b = {2'b00, dt_q};
				ram_addr  = nidx_full[SINE_IDX_W-1:0];
			end
			ST_VEL: begin
				req.mul_a = MUL_A_W'(sp_q);
				req.mul_b = {2'b00, dt_q};
			end
			ST_MUL_X: begin
				req.mul_a = prod_q[MUL_A_W-1:0];
				req.mul_b = c_q;
			end
			ST_MUL_Z: begin
				req.mul_a = p_q;
				req.mul_b = s_q;
			end
			ST_MUL_H: begin
				req.mul_a = p_q;
				req.mul_b = MUL_B_W'(st_q);
			end
			ST_MOD: begin
				req.op   = ALU_CSUB;
				req.cs_a = v_q;
				req.cs_b = FULL_DEG << step_q;
			end
			default: begin
				req.op = ALU_MUL;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
			fwd_lim_q  <= 16'sd2560;
			bwd_lim_q  <= -16'sd1024;
			left_lim_q <= -16'sd3840;
			right_lim_q <= 16'sd3840;
			cur_sp_q   <= '0;
			cur_st_q   <= '0;
			x_q        <= '0;
			z_q        <= '0;
			hd_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FILL)
				fill_q <= fill_q + 1'b1;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_FWD_SPEED:   fwd_lim_q   <= cfg_data;
					REG_BWD_SPEED:   bwd_lim_q   <= cfg_data;
					REG_LEFT_STEER:  left_lim_q  <= cfg_data;
					REG_RIGHT_STEER: right_lim_q <= cfg_data;
					default:         fwd_lim_q   <= fwd_lim_q;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
				cur_sp_q   <= deadband16(sp_q);
				cur_st_q   <= deadband16(st_q);
				x_q        <= x_new_q;
				z_q        <= z_new_q;
				hd_q       <= v_q[24:0];
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= rsp.prod;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					tsp_q <= s_tdata[15:0];
					tst_q <= s_tdata[31:16];
					dt_q  <= s_tdata[47:32];
				end
			end
			ST_QUAD_HI: begin
				rw_q      <= rsp.rem[24:0];
				quad_q[1] <= rsp.ge;
			end
			ST_QUAD_LO: begin
				rw_q      <= rsp.rem[24:0];
				quad_q[0] <= rsp.ge;
				step_q    <= CNT_W'(SINE_IDX_W - 1);
			end
			ST_DIV: begin
				rw_q   <= rsp.rem[24:0];
				idx_q  <= {idx_q[SINE_IDX_W-2:0], rsp.ge};
				step_q <= step_q - 1'b1;
			end
			ST_LAG_ST: begin
				ma_q <= ram_rdata;
				sp_q <= clamp16(sp_sum, bwd_lim_q, fwd_lim_q);
			end
			ST_VEL: begin
				st_q <= clamp16(st_sum, left_lim_q, right_lim_q);
				c_q  <= c_val;
				s_q  <= s_val;
			end
			ST_MUL_X: begin
				p_q <= prod_q[MUL_A_W-1:0];
			end
			ST_MUL_Z: begin
				x_new_q <= x_q + x_shift[31:0];
			end
			ST_MUL_H: begin
				z_new_q <= z_q + x_shift[31:0];
			end
			ST_MOD_INIT: begin
				// bias by 128 turns so the sum is positive, then peel turns off
				v_q    <= {{(CS_W - 25){1'b0}}, hd_q} + dh_shift[CS_W-1:0] + (FULL_DEG << 7);
				step_q <= CNT_W'(MOD_STEPS - 1);
			end
			ST_MOD: begin
				v_q    <= rsp.rem;
				step_q <= step_q - 1'b1;
			end
			ST_DONE: begin
				if (out_free)
					m_tdata_q <= {7'b0, deadband16(st_q), deadband16(sp_q), v_q[24:0],
						z_new_q, x_new_q};
			end
			default: begin
			end
		endcase
	end

endmodule
